// ===== rtl/tfr_pkg.sv =====
// Shared types, constants and codes of the transfer frame reassembler.
package tfr_pkg;

  localparam int PAYLOAD_BYTES = 219;
  localparam int BUFFER_BYTES  = 2048;

  localparam logic [31:0] SYNC_MARKER_RESET  = 32'h1ACF_FC1D;
  localparam logic [15:0] LENGTH_LIMIT_RESET = 16'd2000;

  localparam int POS_W  = (PAYLOAD_BYTES > 1) ? $clog2(PAYLOAD_BYTES) : 1;
  localparam int BASE_W = $clog2(256 * PAYLOAD_BYTES);
  localparam int ADDR_W = BASE_W + 1;

  localparam logic [10:0] LENGTH_SAT = 11'h7FF;

  typedef enum logic [2:0] {
    EV_PAYLOAD  = 3'd0,
    EV_BAD_SYNC = 3'd1,
    EV_IDLE     = 3'd2,
    EV_LOSS     = 3'd3,
    EV_ACCEPT   = 3'd4
  } event_t;

  typedef enum logic [1:0] {
    REG_SYNC_CHECK   = 2'd0,
    REG_SYNC_MARKER  = 2'd1,
    REG_LENGTH_LIMIT = 2'd2
  } reg_idx_t;

  typedef struct packed {
    logic        sync_check_on;
    logic [31:0] sync_marker;
    logic [15:0] length_limit;
  } cfg_t;

  typedef struct packed {
    logic              is_payload;
    logic              sync_bad;
    logic              idle;
    logic [7:0]        idx;
    logic [7:0]        seq;
    logic [15:0]       len;
    logic [BASE_W-1:0] base;
    logic              is_final;
    logic [7:0]        data;
  } item_t;

  typedef struct packed {
    logic [2:0]  header_event;
    logic        open_buffer;
    logic        drop_buffer;
    logic        write_enable;
    logic [10:0] write_address;
    logic [7:0]  write_data;
    logic        packet_done;
    logic [10:0] packet_length;
  } result_t;

endpackage

// ===== rtl/tfr_cfg.sv =====
// Configuration registers behind the APB-style port.
module tfr_cfg (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [3:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  output tfr_pkg::cfg_t     cfg
);

  tfr_pkg::cfg_t cfg_r;
  tfr_pkg::reg_idx_t ridx;
  logic wr_en;

  assign pready = 1'b1;
  assign ridx   = tfr_pkg::reg_idx_t'(paddr[3:2]);
  assign wr_en  = psel && penable && pwrite;
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.sync_check_on <= 1'b1;
      cfg_r.sync_marker   <= tfr_pkg::SYNC_MARKER_RESET;
      cfg_r.length_limit  <= tfr_pkg::LENGTH_LIMIT_RESET;
    end else if (wr_en) begin
      unique case (ridx)
        tfr_pkg::REG_SYNC_CHECK:   cfg_r.sync_check_on <= pwdata[0];
        tfr_pkg::REG_SYNC_MARKER:  cfg_r.sync_marker   <= pwdata;
        tfr_pkg::REG_LENGTH_LIMIT: cfg_r.length_limit  <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (ridx)
      tfr_pkg::REG_SYNC_CHECK:   prdata = {31'd0, cfg_r.sync_check_on};
      tfr_pkg::REG_SYNC_MARKER:  prdata = cfg_r.sync_marker;
      tfr_pkg::REG_LENGTH_LIMIT: prdata = {16'd0, cfg_r.length_limit};
      default:                   prdata = 32'd0;
    endcase
  end

endmodule

// ===== rtl/tfr_front.sv =====
// Front end: classify incoming items and queue them for the back end.
module tfr_front (
  input  logic              clk,
  input  logic              rst_n,
  input  tfr_pkg::cfg_t     cfg,
  input  logic              push,
  output logic              full,
  input  logic              in_operation,
  input  logic [31:0]       in_sync_word,
  input  logic [7:0]        in_frame_number,
  input  logic [7:0]        in_packet_sequence,
  input  logic [15:0]       in_total_length,
  input  logic [7:0]        in_payload_byte,
  output logic              q_valid,
  output tfr_pkg::item_t    q_item,
  input  logic              q_pop
);

  tfr_pkg::item_t mem_r [2];
  tfr_pkg::item_t item;
  logic                       wr_ptr_r, rd_ptr_r;
  logic [1:0]                 count_r, count_nxt;
  logic                       do_push, do_pop;
  logic [tfr_pkg::ADDR_W-1:0] fin_lim;

  assign full    = (count_r == 2'd2);
  assign q_valid = (count_r != 2'd0);
  assign q_item  = mem_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = q_pop && q_valid;

  always_comb begin
    item            = '0;
    item.is_payload = in_operation;
    item.sync_bad   = cfg.sync_check_on && (in_sync_word != cfg.sync_marker);
    item.idle       = (in_total_length == 16'd0) || (in_total_length > cfg.length_limit);
    item.idx        = in_frame_number;
    item.seq        = in_packet_sequence;
    item.len        = in_total_length;
    item.base       = tfr_pkg::BASE_W'(32'(in_frame_number) * tfr_pkg::PAYLOAD_BYTES);
    fin_lim         = tfr_pkg::ADDR_W'(item.base) + tfr_pkg::ADDR_W'(tfr_pkg::PAYLOAD_BYTES);
    item.is_final   = (32'(in_total_length) <= 32'(fin_lim));
    item.data       = in_payload_byte;
  end

  always_comb begin
    count_nxt = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 2'd1;
    end else if (!do_push && do_pop) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      count_r <= count_nxt;
      if (do_push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (do_pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= item;
    end
  end

endmodule

// ===== rtl/tfr_back.sv =====
// Back end: reassembly state, buffer write generation and result queue.
module tfr_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_valid,
  input  tfr_pkg::item_t    q_item,
  output logic              q_pop,
  output logic              empty,
  input  logic              pop,
  output tfr_pkg::result_t  res
);

  logic [7:0]                 held_seq_r, held_seq_nxt;
  logic                       seq_known_r, seq_known_nxt;
  logic [8:0]                 last_idx_r, last_idx_nxt;
  logic                       buf_open_r, buf_open_nxt;
  logic                       taken_r, taken_nxt;
  logic                       final_r, final_nxt;
  logic [tfr_pkg::BASE_W-1:0] base_r, base_nxt;
  logic [15:0]                len_r, len_nxt;
  logic [tfr_pkg::POS_W-1:0]  pos_r, pos_nxt;

  tfr_pkg::result_t           rq_mem_r [2];
  tfr_pkg::result_t           r;
  logic                       rq_wr_r, rq_rd_r;
  logic [1:0]                 rq_cnt_r, rq_cnt_nxt;
  logic                       rq_full, rq_pop;

  logic [tfr_pkg::ADDR_W-1:0] addr;
  logic                       seq_bad;
  logic [8:0]                 idx_next;

  assign rq_full = (rq_cnt_r == 2'd2);
  assign empty   = (rq_cnt_r == 2'd0);
  assign rq_pop  = pop && !empty;
  assign q_pop   = q_valid && !rq_full;
  assign res     = rq_mem_r[rq_rd_r];

  assign addr     = tfr_pkg::ADDR_W'(base_r) + tfr_pkg::ADDR_W'(pos_r);
  assign idx_next = last_idx_r + 9'd1;
  assign seq_bad  = !seq_known_r || (held_seq_r != q_item.seq) ||
                    (idx_next != {1'b0, q_item.idx});

  always_comb begin
    held_seq_nxt  = held_seq_r;
    seq_known_nxt = seq_known_r;
    last_idx_nxt  = last_idx_r;
    buf_open_nxt  = buf_open_r;
    taken_nxt     = taken_r;
    final_nxt     = final_r;
    base_nxt      = base_r;
    len_nxt       = len_r;
    pos_nxt       = pos_r;
    r             = '0;
    r.header_event = tfr_pkg::EV_PAYLOAD;
    if (!q_item.is_payload) begin
      taken_nxt = 1'b0;
      pos_nxt   = '0;
      if (q_item.sync_bad) begin
        r.header_event = tfr_pkg::EV_BAD_SYNC;
      end else if (q_item.idle) begin
        r.header_event = tfr_pkg::EV_IDLE;
      end else if ((q_item.idx != 8'd0) && seq_bad) begin
        r.header_event = tfr_pkg::EV_LOSS;
        r.drop_buffer  = buf_open_r;
        buf_open_nxt   = 1'b0;
      end else begin
        if (q_item.idx == 8'd0) begin
          held_seq_nxt  = q_item.seq;
          seq_known_nxt = 1'b1;
        end
        last_idx_nxt   = {1'b0, q_item.idx};
        r.header_event = tfr_pkg::EV_ACCEPT;
        r.open_buffer  = !buf_open_r;
        buf_open_nxt   = 1'b1;
        taken_nxt      = 1'b1;
        base_nxt       = q_item.base;
        len_nxt        = q_item.len;
        final_nxt      = q_item.is_final;
      end
    end else if (!taken_r || (32'(pos_r) >= 32'(tfr_pkg::PAYLOAD_BYTES))) begin
      taken_nxt = 1'b0;
    end else begin
      if ((32'(addr) < 32'(len_r)) && (32'(addr) < 32'(tfr_pkg::BUFFER_BYTES))) begin
        r.write_enable  = 1'b1;
        r.write_address = addr[10:0];
        r.write_data    = q_item.data;
      end
      if (32'(pos_r) + 32'd1 >= 32'(tfr_pkg::PAYLOAD_BYTES)) begin
        taken_nxt = 1'b0;
        pos_nxt   = '0;
        if (final_r) begin
          r.packet_done   = 1'b1;
          r.packet_length = (len_r > 16'(tfr_pkg::LENGTH_SAT)) ?
                            tfr_pkg::LENGTH_SAT : len_r[10:0];
          buf_open_nxt    = 1'b0;
        end
      end else begin
        pos_nxt = pos_r + tfr_pkg::POS_W'(1);
      end
    end
  end

  always_comb begin
    rq_cnt_nxt = rq_cnt_r;
    if (q_pop && !rq_pop) begin
      rq_cnt_nxt = rq_cnt_r + 2'd1;
    end else if (!q_pop && rq_pop) begin
      rq_cnt_nxt = rq_cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_seq_r  <= 8'd0;
      seq_known_r <= 1'b0;
      last_idx_r  <= 9'h1FF;
      buf_open_r  <= 1'b0;
      taken_r     <= 1'b0;
      final_r     <= 1'b0;
      base_r      <= '0;
      len_r       <= 16'd0;
      pos_r       <= '0;
      rq_wr_r     <= 1'b0;
      rq_rd_r     <= 1'b0;
      rq_cnt_r    <= 2'd0;
    end else begin
      rq_cnt_r <= rq_cnt_nxt;
      if (rq_pop) begin
        rq_rd_r <= !rq_rd_r;
      end
      if (q_pop) begin
        rq_wr_r     <= !rq_wr_r;
        held_seq_r  <= held_seq_nxt;
        seq_known_r <= seq_known_nxt;
        last_idx_r  <= last_idx_nxt;
        buf_open_r  <= buf_open_nxt;
        taken_r     <= taken_nxt;
        final_r     <= final_nxt;
        base_r      <= base_nxt;
        len_r       <= len_nxt;
        pos_r       <= pos_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      rq_mem_r[rq_wr_r] <= r;
    end
  end

endmodule

// ===== rtl/transfer_frame_reassembler.sv =====
// Top level of the transfer frame reassembler.
//
//   channel   handshake             transaction when
//   input     push / full           push && !full
//   result    empty / pop           pop && !empty
//   config    psel penable pwrite   psel && penable && pwrite (pready tied high)
//
// One item per cycle sustained while pop keeps the result queue from filling; a result
// passes through the input queue, then the back-end state update into the result queue.
// Each side has a two-entry queue; with pop held low, four transactions are taken
// before full rises.
// Synchronous active-low reset clears queues and reassembly state; registers
// return to their defaults.
module transfer_frame_reassembler (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        push,
  output logic        full,
  input  logic        in_operation,
  input  logic [31:0] in_sync_word,
  input  logic [7:0]  in_frame_number,
  input  logic [7:0]  in_packet_sequence,
  input  logic [15:0] in_total_length,
  input  logic [7:0]  in_payload_byte,
  output logic        empty,
  input  logic        pop,
  output logic [2:0]  out_header_event,
  output logic        out_open_buffer,
  output logic        out_drop_buffer,
  output logic        out_write_enable,
  output logic [10:0] out_write_address,
  output logic [7:0]  out_write_data,
  output logic        out_packet_done,
  output logic [10:0] out_packet_length
);

  tfr_pkg::cfg_t    cfg;
  tfr_pkg::item_t   q_item;
  tfr_pkg::result_t res;
  logic             q_valid, q_pop;

  tfr_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  tfr_front u_front (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg                (cfg),
    .push               (push),
    .full               (full),
    .in_operation       (in_operation),
    .in_sync_word       (in_sync_word),
    .in_frame_number    (in_frame_number),
    .in_packet_sequence (in_packet_sequence),
    .in_total_length    (in_total_length),
    .in_payload_byte    (in_payload_byte),
    .q_valid            (q_valid),
    .q_item             (q_item),
    .q_pop              (q_pop)
  );

  tfr_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_valid (q_valid),
    .q_item  (q_item),
    .q_pop   (q_pop),
    .empty   (empty),
    .pop     (pop),
    .res     (res)
  );

  assign out_header_event  = res.header_event;
  assign out_open_buffer   = res.open_buffer;
  assign out_drop_buffer   = res.drop_buffer;
  assign out_write_enable  = res.write_enable;
  assign out_write_address = res.write_address;
  assign out_write_data    = res.write_data;
  assign out_packet_done   = res.packet_done;
  assign out_packet_length = res.packet_length;

endmodule

// ===== dv/tb_transfer_frame_reassembler.sv =====
`timescale 1ns / 100ps
// Testbench for the transfer frame reassembler: queued frame traffic against a predictor.
module tb_transfer_frame_reassembler;

  localparam logic OP_HEADER  = 1'b0;
  localparam logic OP_PAYLOAD = 1'b1;
  localparam int   MAX_WAIT   = 14;

  typedef struct {
    logic        op;
    logic [31:0] sync;
    logic [7:0]  idx;
    logic [7:0]  seq;
    logic [15:0] len;
    logic [7:0]  data;
  } link_item_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        push = 1'b0;
  logic        full;
  logic        in_operation = 1'b0;
  logic [31:0] in_sync_word = '0;
  logic [7:0]  in_frame_number = '0;
  logic [7:0]  in_packet_sequence = '0;
  logic [15:0] in_total_length = '0;
  logic [7:0]  in_payload_byte = '0;
  logic        empty;
  logic        pop = 1'b0;
  logic [2:0]  out_header_event;
  logic        out_open_buffer;
  logic        out_drop_buffer;
  logic        out_write_enable;
  logic [10:0] out_write_address;
  logic [7:0]  out_write_data;
  logic        out_packet_done;
  logic [10:0] out_packet_length;

  transfer_frame_reassembler dut (.*);

  always #5 clk = ~clk;

  // register copies
  logic        chk_on = 1'b1;
  logic [31:0] marker = tfr_pkg::SYNC_MARKER_RESET;
  logic [15:0] len_limit = tfr_pkg::LENGTH_LIMIT_RESET;

  // reassembly state
  logic [7:0]  held_seq = '0;
  logic        seq_known = 1'b0;
  logic [8:0]  last_idx = '1;
  logic        buf_open = 1'b0;
  logic        taken = 1'b0;
  logic        is_final = 1'b0;
  logic [7:0]  cur_idx = '0;
  logic [15:0] cur_len = '0;
  int          pos = 0;

  link_item_t       link_items[$];
  tfr_pkg::result_t buffer_ops_due[$];
  link_item_t       on_wire;

  int mismatches = 0;
  int n_sent = 0;
  int n_checked = 0;
  int n_accept = 0;
  int n_done = 0;
  int n_loss = 0;
  int n_writes = 0;
  int n_queued = 0;
  int send_wait = 0;
  int send_streak = 0;
  int pop_wait = 0;
  int pop_streak = 0;

  task automatic track_reassembly(input link_item_t it, output tfr_pkg::result_t r);
    int addr;
    r = '0;
    r.header_event = tfr_pkg::EV_PAYLOAD;
    if (it.op == OP_HEADER) begin
      taken = 1'b0;
      pos = 0;
      if (chk_on && it.sync != marker) begin
        r.header_event = tfr_pkg::EV_BAD_SYNC;
      end else if (it.len == 16'd0 || it.len > len_limit) begin
        r.header_event = tfr_pkg::EV_IDLE;
      end else if (it.idx != 8'd0 && (!seq_known || held_seq != it.seq ||
                   (last_idx + 9'd1) != {1'b0, it.idx})) begin
        r.header_event = tfr_pkg::EV_LOSS;
        r.drop_buffer = buf_open;
        buf_open = 1'b0;
        n_loss++;
      end else begin
        if (it.idx == 8'd0) begin
          held_seq = it.seq;
          seq_known = 1'b1;
        end
        last_idx = {1'b0, it.idx};
        r.header_event = tfr_pkg::EV_ACCEPT;
        r.open_buffer = !buf_open;
        buf_open = 1'b1;
        taken = 1'b1;
        cur_idx = it.idx;
        cur_len = it.len;
        is_final = (int'(it.len) <= (int'(it.idx) + 1) * tfr_pkg::PAYLOAD_BYTES);
        n_accept++;
      end
    end else if (!taken || pos >= tfr_pkg::PAYLOAD_BYTES) begin
      taken = 1'b0;
    end else begin
      addr = int'(cur_idx) * tfr_pkg::PAYLOAD_BYTES + pos;
      if (addr < int'(cur_len) && addr < tfr_pkg::BUFFER_BYTES) begin
        r.write_enable = 1'b1;
        r.write_address = addr[10:0];
        r.write_data = it.data;
        n_writes++;
      end
      if (pos + 1 >= tfr_pkg::PAYLOAD_BYTES) begin
        taken = 1'b0;
        pos = 0;
        if (is_final) begin
          r.packet_done = 1'b1;
          r.packet_length = (cur_len > 16'd2047) ? tfr_pkg::LENGTH_SAT : cur_len[10:0];
          buf_open = 1'b0;
          n_done++;
        end
      end else begin
        pos++;
      end
    end
  endtask

  function automatic int draw_wait(inout int streak);
    if (streak > 0) begin
      streak--;
      return 0;
    end
    if ($urandom_range(0, 49) == 0) begin
      streak = $urandom_range(20, 80);
      return 0;
    end
    return ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(0, MAX_WAIT);
  endfunction

  function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0d, actual %0d", name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin
    tfr_pkg::result_t due;
    if (!rst_n) begin
      push <= 1'b0;
    end else begin
      if (push && !full) begin
        track_reassembly(on_wire, due);
        buffer_ops_due.push_back(due);
        n_sent++;
      end
      if (!push || !full) begin
        if (send_wait > 0) begin
          send_wait--;
          push <= 1'b0;
        end else if (link_items.size() > 0) begin
          on_wire = link_items.pop_front();
          push <= 1'b1;
          in_operation <= on_wire.op;
          in_sync_word <= on_wire.sync;
          in_frame_number <= on_wire.idx;
          in_packet_sequence <= on_wire.seq;
          in_total_length <= on_wire.len;
          in_payload_byte <= on_wire.data;
          send_wait = draw_wait(send_streak);
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    tfr_pkg::result_t want;
    if (!rst_n) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (buffer_ops_due.size() == 0) begin
          $error("unexpected transaction: header_event %0d", out_header_event);
          mismatches++;
        end else begin
          want = buffer_ops_due.pop_front();
          check_field("header_event", want.header_event, out_header_event);
          check_field("open_buffer", want.open_buffer, out_open_buffer);
          check_field("drop_buffer", want.drop_buffer, out_drop_buffer);
          check_field("write_enable", want.write_enable, out_write_enable);
          check_field("write_address", want.write_address, out_write_address);
          check_field("write_data", want.write_data, out_write_data);
          check_field("packet_done", want.packet_done, out_packet_done);
          check_field("packet_length", want.packet_length, out_packet_length);
        end
        n_checked++;
        pop_wait = draw_wait(pop_streak);
      end
      if (pop_wait > 0) begin
        pop_wait--;
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  task automatic write_reg(tfr_pkg::reg_idx_t r, logic [31:0] v);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {r, 2'b00};
    pwdata <= v;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (r)
      tfr_pkg::REG_SYNC_CHECK:   chk_on = v[0];
      tfr_pkg::REG_SYNC_MARKER:  marker = v;
      tfr_pkg::REG_LENGTH_LIMIT: len_limit = v[15:0];
      default: ;
    endcase
  endtask

  task automatic set_config(logic chk, logic [31:0] mk, logic [15:0] lim);
    write_reg(tfr_pkg::REG_SYNC_CHECK, {31'd0, chk});
    write_reg(tfr_pkg::REG_SYNC_MARKER, mk);
    write_reg(tfr_pkg::REG_LENGTH_LIMIT, {16'd0, lim});
  endtask

  task automatic add_header(logic [31:0] sync, logic [7:0] idx, logic [7:0] seq,
                            logic [15:0] len);
    link_item_t it;
    it = '{OP_HEADER, sync, idx, seq, len, 8'($urandom)};
    link_items.push_back(it);
    n_queued++;
  endtask

  task automatic add_data(logic [7:0] d);
    link_item_t it;
    it = '{OP_PAYLOAD, $urandom, 8'($urandom), 8'($urandom), 16'($urandom), d};
    link_items.push_back(it);
    n_queued++;
  endtask

  task automatic add_bytes(int n);
    for (int i = 0; i < n; i++) add_data(8'($urandom));
  endtask

  function automatic logic [31:0] good_sync();
    return chk_on ? marker : 32'($urandom);
  endfunction

  function automatic int pick_length();
    int hi;
    hi = (len_limit < 16'd2600) ? int'(len_limit) : 2600;
    if ($urandom_range(0, 3) != 0 && hi > tfr_pkg::PAYLOAD_BYTES) hi = tfr_pkg::PAYLOAD_BYTES;
    return $urandom_range(1, hi);
  endfunction

  // frames 0..n of one packet; most leading frames cut short, last frame mostly full
  task automatic add_packet(int len);
    logic [7:0] seq;
    int frames;
    int body;
    seq = 8'($urandom);
    frames = (len + tfr_pkg::PAYLOAD_BYTES - 1) / tfr_pkg::PAYLOAD_BYTES +
             (($urandom_range(0, 7) == 0) ? 1 : 0);
    for (int f = 0; f < frames; f++) begin
      add_header(good_sync(), 8'(f), seq, 16'(len));
      if (f == frames - 1)
        body = ($urandom_range(0, 9) == 0) ?
               $urandom_range(0, tfr_pkg::PAYLOAD_BYTES + 3) : tfr_pkg::PAYLOAD_BYTES;
      else if ($urandom_range(0, 9) == 0)
        body = tfr_pkg::PAYLOAD_BYTES;
      else
        body = $urandom_range(0, 6);
      add_bytes(body);
      if ($urandom_range(0, 19) == 0) add_header(good_sync(), 8'(f + 2), seq, 16'(len));
    end
  endtask

  task automatic add_noise();
    case ($urandom_range(0, 5))
      0: add_bytes($urandom_range(1, 4));
      1: add_header($urandom, 8'($urandom), 8'($urandom), 16'($urandom));
      2: add_header(good_sync(), 8'($urandom), 8'($urandom),
                    (len_limit == 16'hFFFF || $urandom_range(0, 3) == 0) ? 16'd0 :
                    16'($urandom_range(int'(len_limit) + 1, 65535)));
      3: add_header(good_sync(), 8'($urandom_range(1, 255)), 8'($urandom),
                    16'($urandom_range(1, 65535)));
      4: begin
        add_header(good_sync(), 8'd0, 8'($urandom), 16'($urandom));
        add_bytes($urandom_range(0, 5));
        add_header(good_sync(), 8'd1, 8'($urandom), 16'($urandom));
      end
      default: begin
        add_header(good_sync(), 8'($urandom), 8'($urandom), 16'($urandom));
        add_bytes($urandom_range(0, 8));
      end
    endcase
  endtask

  task automatic run_random(int n);
    int stop;
    stop = n_queued + n;
    while (n_queued < stop) begin
      if (len_limit != 16'd0 && $urandom_range(0, 9) < 7) add_packet(pick_length());
      else add_noise();
    end
  endtask

  task automatic settle();
    while (link_items.size() != 0 || push || buffer_ops_due.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    add_data(8'h5A);
    add_header(32'h0, 8'd0, 8'd0, 16'd10);
    add_header(tfr_pkg::SYNC_MARKER_RESET, 8'd0, 8'd0, 16'd0);
    add_header(tfr_pkg::SYNC_MARKER_RESET, 8'd0, 8'd0, 16'd2001);
    add_header(tfr_pkg::SYNC_MARKER_RESET, 8'd0, 8'd0, 16'hFFFF);
    add_header(tfr_pkg::SYNC_MARKER_RESET, 8'd7, 8'd1, 16'd100);
    add_header(tfr_pkg::SYNC_MARKER_RESET, 8'd0, 8'hFF, 16'd2000);
    add_data(8'h00);
    add_data(8'hFF);
    add_data(8'hA5);
    add_header(tfr_pkg::SYNC_MARKER_RESET, 8'd1, 8'hFF, 16'd2000);
    add_data(8'hFF);
    add_header(tfr_pkg::SYNC_MARKER_RESET, 8'd3, 8'hFF, 16'd2000);
    add_header(tfr_pkg::SYNC_MARKER_RESET, 8'd255, 8'd0, 16'd1);
    add_header(32'hFFFF_FFFF, 8'd0, 8'd0, 16'd1);
    run_random(40);
    settle();

    set_config(1'b0, $urandom, 16'hFFFF);
    add_packet(2100);
    run_random(20);
    settle();

    set_config(1'b1, 32'hFFFF_FFFF, 16'd2047);
    run_random(20);
    settle();

    set_config(1'b1, 32'h0, 16'd1);
    run_random(1);
    settle();

    set_config(1'b0, tfr_pkg::SYNC_MARKER_RESET, 16'd0);
    run_random(30);
    settle();

    set_config(1'b1, $urandom, tfr_pkg::LENGTH_LIMIT_RESET);
    run_random(20);
    settle();

    $display("Checked %0d results from %0d input transactions over six register settings.",
             n_checked, n_sent);
    $display("Headers accepted %0d, packets completed %0d, loss discards %0d, buffer writes %0d.",
             n_accept, n_done, n_loss, n_writes);
    if (mismatches == 0) begin
      $display("tb_transfer_frame_reassembler passed");
    end else begin
      $display("tb_transfer_frame_reassembler failed");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("tb_transfer_frame_reassembler failed");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/tfr_pkg.sv
rtl/tfr_cfg.sv
rtl/tfr_front.sv
rtl/tfr_back.sv
rtl/transfer_frame_reassembler.sv
dv/tb_transfer_frame_reassembler.sv
